FILE: rtl/mlp_pkg.sv
// Package: shared constants, control-word types and the microcode program of the perceptron.
`timescale 1ns / 1ps
package mlp_pkg;

	// Default datapath format: signed Q8.8.
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	// Fixed beat field widths.
	localparam int FIELD_W = 16;
	localparam int IDX_W   = 6;

	// Parameter store layout.
	localparam int STORE_WORDS = 40;
	localparam int W1_BASE     = 0;
	localparam int W2_BASE     = 8;
	localparam int W3_BASE     = 24;
	localparam int B1_BASE     = 32;
	localparam int B2_BASE     = 36;

	// Activation register file: two inputs, then hidden layer one, then hidden layer two.
	localparam int ACT_WORDS = 10;
	localparam int ACT_IDX_W = 4;
	localparam int ACT_X     = 0;
	localparam int ACT_H1    = 2;
	localparam int ACT_H2    = 6;

	// Program counter width and program length.
	localparam int PC_W     = 6;
	localparam int PROG_LEN = 46;

	// Command codes carried by an input beat.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_INFER = 1'b1;

	// Datapath operation of one control word.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_NOP,
		OP_MAC_FIRST,
		OP_MAC,
		OP_MAC_OUT,
		OP_BIAS_ACT,
		OP_END
	} op_t;

	// Jump condition of one control word.
	typedef enum logic [1:0] {
		JC_NONE,
		JC_NO_START,
		JC_OUT_BUSY
	} jcond_t;

	// One microcode word.
	typedef struct packed {
		op_t                  op;
		jcond_t               jc;
		logic [PC_W-1:0]      target;
		logic [IDX_W-1:0]     addr;
		logic [ACT_IDX_W-1:0] src;
		logic [ACT_IDX_W-1:0] dst;
	} ctrl_t;

	// Build one control word.
	function automatic ctrl_t cw(input op_t op, input jcond_t jc, input int target,
			input int addr, input int src, input int dst);
		ctrl_t c;
		c.op     = op;
		c.jc     = jc;
		c.target = PC_W'(target);
		c.addr   = IDX_W'(addr);
		c.src    = ACT_IDX_W'(src);
		c.dst    = ACT_IDX_W'(dst);
		return c;
	endfunction

	// The microcode program. Step 0 waits for an infer beat. Each hidden neuron is a run of
	// multiply-accumulate steps closed by a bias step; each output neuron closes with a
	// saturating store. A spare step separates layers so that the next layer reads settled
	// activations, and two spare steps let the last output settle before the result is shown.
	function automatic ctrl_t prog_rom(input logic [PC_W-1:0] pc);
		ctrl_t r;
		case (pc)
			6'd0:  r = cw(OP_IDLE,      JC_NO_START, 0,  0,           0,          0);
			// Hidden layer one.
			6'd1:  r = cw(OP_MAC_FIRST, JC_NONE,     0,  W1_BASE + 0, ACT_X + 0,  0);
			6'd2:  r = cw(OP_MAC,       JC_NONE,     0,  W1_BASE + 1, ACT_X + 1,  0);
			6'd3:  r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B1_BASE + 0, 0,          ACT_H1 + 0);
			6'd4:  r = cw(OP_MAC_FIRST, JC_NONE,     0,  W1_BASE + 2, ACT_X + 0,  0);
			6'd5:  r = cw(OP_MAC,       JC_NONE,     0,  W1_BASE + 3, ACT_X + 1,  0);
			6'd6:  r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B1_BASE + 1, 0,          ACT_H1 + 1);
			6'd7:  r = cw(OP_MAC_FIRST, JC_NONE,     0,  W1_BASE + 4, ACT_X + 0,  0);
			6'd8:  r = cw(OP_MAC,       JC_NONE,     0,  W1_BASE + 5, ACT_X + 1,  0);
			6'd9:  r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B1_BASE + 2, 0,          ACT_H1 + 2);
			6'd10: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W1_BASE + 6, ACT_X + 0,  0);
			6'd11: r = cw(OP_MAC,       JC_NONE,     0,  W1_BASE + 7, ACT_X + 1,  0);
			6'd12: r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B1_BASE + 3, 0,          ACT_H1 + 3);
			6'd13: r = cw(OP_NOP,       JC_NONE,     0,  0,           0,          0);
			// Hidden layer two.
			6'd14: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W2_BASE + 0,  ACT_H1 + 0, 0);
			6'd15: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 1,  ACT_H1 + 1, 0);
			6'd16: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 2,  ACT_H1 + 2, 0);
			6'd17: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 3,  ACT_H1 + 3, 0);
			6'd18: r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B2_BASE + 0,  0,          ACT_H2 + 0);
			6'd19: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W2_BASE + 4,  ACT_H1 + 0, 0);
			6'd20: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 5,  ACT_H1 + 1, 0);
			6'd21: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 6,  ACT_H1 + 2, 0);
			6'd22: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 7,  ACT_H1 + 3, 0);
			6'd23: r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B2_BASE + 1,  0,          ACT_H2 + 1);
			6'd24: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W2_BASE + 8,  ACT_H1 + 0, 0);
			6'd25: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 9,  ACT_H1 + 1, 0);
			6'd26: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 10, ACT_H1 + 2, 0);
			6'd27: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 11, ACT_H1 + 3, 0);
			6'd28: r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B2_BASE + 2,  0,          ACT_H2 + 2);
			6'd29: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W2_BASE + 12, ACT_H1 + 0, 0);
			6'd30: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 13, ACT_H1 + 1, 0);
			6'd31: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 14, ACT_H1 + 2, 0);
			6'd32: r = cw(OP_MAC,       JC_NONE,     0,  W2_BASE + 15, ACT_H1 + 3, 0);
			6'd33: r = cw(OP_BIAS_ACT,  JC_NONE,     0,  B2_BASE + 3,  0,          ACT_H2 + 3);
			6'd34: r = cw(OP_NOP,       JC_NONE,     0,  0,            0,          0);
			// Output layer.
			6'd35: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W3_BASE + 0,  ACT_H2 + 0, 0);
			6'd36: r = cw(OP_MAC,       JC_NONE,     0,  W3_BASE + 1,  ACT_H2 + 1, 0);
			6'd37: r = cw(OP_MAC,       JC_NONE,     0,  W3_BASE + 2,  ACT_H2 + 2, 0);
			6'd38: r = cw(OP_MAC_OUT,   JC_NONE,     0,  W3_BASE + 3,  ACT_H2 + 3, 0);
			6'd39: r = cw(OP_MAC_FIRST, JC_NONE,     0,  W3_BASE + 4,  ACT_H2 + 0, 0);
			6'd40: r = cw(OP_MAC,       JC_NONE,     0,  W3_BASE + 5,  ACT_H2 + 1, 0);
			6'd41: r = cw(OP_MAC,       JC_NONE,     0,  W3_BASE + 6,  ACT_H2 + 2, 0);
			6'd42: r = cw(OP_MAC_OUT,   JC_NONE,     0,  W3_BASE + 7,  ACT_H2 + 3, 1);
			6'd43: r = cw(OP_NOP,       JC_NONE,     0,  0,            0,          0);
			6'd44: r = cw(OP_NOP,       JC_NONE,     0,  0,            0,          0);
			// Hold here while the previous result is still waiting.
			6'd45: r = cw(OP_END,       JC_OUT_BUSY, 45, 0,            0,          0);
			default: r = cw(OP_NOP,     JC_NONE,     0,  0,            0,          0);
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/mlp_in_if.sv
// Interface: input channel carrying load and infer beats.
`timescale 1ns / 1ps
interface mlp_in_if;
	import mlp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [IDX_W-1:0]          param_index;
	logic signed [FIELD_W-1:0] param_value;
	logic signed [FIELD_W-1:0] input_x;
	logic signed [FIELD_W-1:0] input_y;

	modport source (output valid, cmd, param_index, param_value, input_x, input_y,
		input ready);
	modport sink (input valid, cmd, param_index, param_value, input_x, input_y,
		output ready);
endinterface

FILE: rtl/mlp_out_if.sv
// Interface: output channel carrying the two network outputs.
`timescale 1ns / 1ps
interface mlp_out_if;
	import mlp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] out_first;
	logic signed [FIELD_W-1:0] out_second;

	modport source (output valid, out_first, out_second, input ready);
	modport sink (input valid, out_first, out_second, output ready);
endinterface

FILE: rtl/mlp_2_4_4_2_relu_infer_unit.sv
// Top level: microcoded forward pass of a 2-4-4-2 ReLU perceptron in signed fixed point.
`timescale 1ns / 1ps
//
// Usage. The item channel takes two kinds of beat. A load beat (cmd = 0) writes one word of
// the 40-word parameter store in the cycle it is accepted; addresses 40 to 63 are dropped.
// Load beats can follow each other every cycle while idle and never produce a result. An
// infer beat (cmd = 1) captures input_x and input_y and starts the program; ready stays low
// until the program returns to its wait step.
// Sequencing: the result beat appears once the program has run its steps after the infer
// beat is accepted, and the input is ready again in the same cycle, so infers do not overlap.
// The program length is set by the single multiply-accumulate unit, which takes one program
// step per product or bias (32 products, 8 biases) plus the steps between layers.
// Stalls: the result sits in an output register; a new infer may be accepted while it waits.
// If the receiver still holds off when the next result is ready, the program waits on its
// last step and ready stays low.
// Reset: clears the program counter, the pipeline controls and the output valid, and marks
// every parameter word unwritten, so the store reads as all zero until loaded.
//
module mlp_2_4_4_2_relu_infer_unit #(
	parameter int DATA_WIDTH = mlp_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = mlp_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	mlp_in_if.sink     item,
	mlp_out_if.source  result
);
	import mlp_pkg::*;

	// Activation width holds both the 16-bit inputs and a full data word.
	localparam int AW    = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
	localparam int PW    = AW + DATA_WIDTH;
	localparam int ACC_W = PW - FRAC_BITS + 3;

	localparam logic signed [AW-1:0] LD_HI =
		AW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] LD_LO = -LD_HI - AW'(1);
	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	// Sequencer.
	logic [PC_W-1:0] pc_q, pc_d;
	ctrl_t           cw;
	logic            jump;
	logic            start;
	logic            out_busy;
	logic            end_fire;

	// Parameter store.
	logic [STORE_WORDS-1:0] vld_q;
	logic                   st_we;
	logic signed [AW-1:0]   ld_ext;
	logic [DATA_WIDTH-1:0]  ld_word;
	logic [DATA_WIDTH-1:0]  w_s1;

	// Pipeline.
	ctrl_t                       cw_s1, cw_s2;
	logic                        rvld_s1;
	logic signed [DATA_WIDTH-1:0] w_eff;
	logic signed [AW-1:0]        act_rd;
	logic signed [PW-1:0]        prod_d, prod_s2;
	logic signed [PW-1:0]        term_full;
	logic signed [ACC_W-1:0]     term, sum;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [DATA_WIDTH-1:0] sat_v, relu_v;

	// Activations and results.
	logic signed [AW-1:0]         act_q [ACT_WORDS];
	logic signed [DATA_WIDTH-1:0] res_q [2];
	logic signed [AW-1:0]         res0_ext, res1_ext;
	logic signed [FIELD_W-1:0]    out_first_q, out_second_q;
	logic                         out_vld_q;

	// Handshake decode.
	assign item.ready = (pc_q == '0);
	assign start      = item.valid && (item.cmd == CMD_INFER);
	assign out_busy   = out_vld_q && !result.ready;

	// Next step: conditional jump, wrap on the end step, else advance.
	always_comb begin
		cw = prog_rom(pc_q);
		case (cw.jc)
			JC_NONE:     jump = 1'b0;
			JC_NO_START: jump = !start;
			JC_OUT_BUSY: jump = out_busy;
			default:     jump = 1'b0;
		endcase
		end_fire = (cw.op == OP_END) && !out_busy;
		if (jump) begin
			pc_d = cw.target;
		end else if (cw.op == OP_END) begin
			pc_d = '0;
		end else begin
			pc_d = PC_W'(pc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Load beats: clamp to the data width and write the store.
	assign ld_ext  = AW'(item.param_value);
	assign st_we   = item.valid && item.ready && (item.cmd == CMD_LOAD) &&
		(item.param_index < IDX_W'(STORE_WORDS));
	always_comb begin
		if (ld_ext > LD_HI) begin
			ld_word = LD_HI[DATA_WIDTH-1:0];
		end else if (ld_ext < LD_LO) begin
			ld_word = LD_LO[DATA_WIDTH-1:0];
		end else begin
			ld_word = ld_ext[DATA_WIDTH-1:0];
		end
	end

	// Written-word flags; an unwritten word reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (st_we) begin
			vld_q[item.param_index] <= 1'b1;
		end
	end

	mlp_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (item.param_index),
		.wdata (ld_word),
		.raddr (cw.addr),
		.rdata (w_s1)
	);

	// Stage one: control word and flag travel alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_s1   <= mlp_pkg::cw(OP_NOP, JC_NONE, 0, 0, 0, 0);
			rvld_s1 <= 1'b0;
		end else begin
			cw_s1   <= cw;
			rvld_s1 <= vld_q[cw.addr];
		end
	end

	// Stage two: multiply the weight by the selected activation, or pass a bias through.
	assign w_eff  = rvld_s1 ? $signed(w_s1) : '0;
	assign act_rd = act_q[cw_s1.src];
	assign prod_d = (cw_s1.op == OP_BIAS_ACT) ? PW'(w_eff) : PW'(act_rd) * PW'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_s2 <= mlp_pkg::cw(OP_NOP, JC_NONE, 0, 0, 0, 0);
		end else begin
			cw_s2 <= cw_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_d;
	end

	// Stage three: rescale, accumulate, saturate and apply ReLU.
	always_comb begin
		term_full = (cw_s2.op == OP_BIAS_ACT) ? prod_s2 : (prod_s2 >>> FRAC_BITS);
		term      = $signed(term_full[ACC_W-1:0]);
		sum       = ((cw_s2.op == OP_MAC_FIRST) ? '0 : acc_q) + term;
		if (sum > SAT_HI) begin
			sat_v = SAT_HI[DATA_WIDTH-1:0];
		end else if (sum < SAT_LO) begin
			sat_v = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			sat_v = sum[DATA_WIDTH-1:0];
		end
		relu_v = sat_v[DATA_WIDTH-1] ? '0 : sat_v;
	end

	always_ff @(posedge clk) begin
		if ((cw_s2.op == OP_MAC_FIRST) || (cw_s2.op == OP_MAC)) begin
			acc_q <= sum;
		end
		if (cw_s2.op == OP_MAC_OUT) begin
			res_q[cw_s2.dst[0]] <= sat_v;
		end
	end

	// Activation file: inputs captured on an infer beat, hidden outputs from stage three.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready && start) begin
			act_q[ACT_X]     <= AW'(item.input_x);
			act_q[ACT_X + 1] <= AW'(item.input_y);
		end
		if (cw_s2.op == OP_BIAS_ACT) begin
			act_q[cw_s2.dst] <= AW'(relu_v);
		end
	end

	// Output register: loaded by the end step, cleared when the beat is taken.
	assign res0_ext = AW'(res_q[0]);
	assign res1_ext = AW'(res_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (end_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			out_first_q  <= res0_ext[FIELD_W-1:0];
			out_second_q <= res1_ext[FIELD_W-1:0];
		end
	end

	assign result.valid      = out_vld_q;
	assign result.out_first  = out_first_q;
	assign result.out_second = out_second_q;

endmodule

FILE: rtl/mlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 40,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/mlp_chk.sv
// Checker: port-level assertions for the perceptron unit, bound to the top level.
`timescale 1ns / 1ps
module mlp_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_cmd,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [15:0]        out_first,
	input logic signed [15:0]        out_second
);
	import mlp_pkg::*;

	logic in_fire;

	assign in_fire = in_valid && in_ready;

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
		else $error("result beat changed while stalled");

	// An infer beat closes the input until its program has run.
	a_busy_after_infer: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_cmd == CMD_INFER) |=> !in_ready)
		else $error("input accepted while an inference is running");

	// A load beat never produces a result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_cmd == CMD_LOAD) && !out_valid |=> !out_valid)
		else $error("result appeared after a load beat");

	// A result never follows at once on the infer beat that starts it.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_cmd == CMD_INFER) && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared too early");

endmodule

bind mlp_2_4_4_2_relu_infer_unit mlp_chk u_mlp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_cmd     (item.cmd),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_first  (result.out_first),
	.out_second (result.out_second)
);
